// File: rtl/core/deq_pkg.sv
`default_nettype none

package deq_pkg;

    // Operation codes carried in the op field of a request beat.
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    // Status codes reported with every response beat.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned STATUS_W = 2;

endpackage

`default_nettype wire

// File: rtl/core/deq_req_if.sv
`default_nettype none

interface deq_req_if
    import deq_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic [DATA_WIDTH-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/deq_rsp_if.sv
`default_nettype none

interface deq_rsp_if
    import deq_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned COUNT_W    = 5
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] front_value;
    logic [DATA_WIDTH-1:0] back_value;
    logic                  is_empty;
    logic [COUNT_W-1:0]    entry_count;
    logic [STATUS_W-1:0]   status;

    modport source (output valid, output front_value, output back_value, output is_empty,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input front_value, input back_value, input is_empty,
                    input entry_count, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/deq_ram.sv
`default_nettype none

module deq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/double_ended_queue_unit.sv
// Channel  Dir  Beat contents
// req      in   op, value
// rsp      out  front_value, back_value, is_empty, entry_count, status
//
// Each request steps through S_IDLE (pointer update and, for a push, the
// entry write), S_READ (reads of the front and back entries) and S_CAPTURE
// (capture into the response register). The response register frees the
// request side, so the next request is taken while a response still waits;
// a stalled response holds the capture step. Reset clears the pointers and
// the count; the entry memories need no clearing.
`default_nettype none

module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    deq_req_if.sink  req,
    deq_rsp_if.source rsp
);

    localparam int unsigned PTR_W   = $clog2(DEPTH);
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CAPTURE
    } state_t;

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    status_t               status_reg, status_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] back_reg, back_next;
    logic                  empty_reg, empty_next;
    logic [CNT_W-1:0]      rsp_count_reg, rsp_count_next;
    status_t               rsp_status_reg, rsp_status_next;

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic                  rd_en;
    logic [PTR_W-1:0]      head_prev, head_succ, tail_prev, tail_succ;
    logic [DATA_WIDTH-1:0] front_rd, back_rd;
    logic                  is_full, is_none;

    // Ring neighbors of both pointers, wrapping at the configured depth.
    always_comb
    begin
        head_prev = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
        head_succ = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        tail_prev = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;
        tail_succ = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
        is_full   = (count_reg == FULL_CNT);
        is_none   = (count_reg == '0);
    end

    // Two copies of the store, one read at the front and one at the back.
    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_front_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (req.value),
        .re    (rd_en),
        .raddr (head_reg),
        .rdata (front_rd)
    );

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_back_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (req.value),
        .re    (rd_en),
        .raddr (tail_prev),
        .rdata (back_rd)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.front_value = front_reg;
    assign rsp.back_value  = back_reg;
    assign rsp.is_empty    = empty_reg;
    assign rsp.entry_count = rsp_count_reg;
    assign rsp.status      = rsp_status_reg;

    // Sequencer: update (and write on a push), read, then load the response register.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        rsp_valid_next  = rsp_valid_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        empty_next      = empty_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_status_next = rsp_status_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_reg;
        rd_en           = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    status_next = ST_OK;
                    case (op_t'(req.op))
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_PUSH_FULL;
                            end
                            else
                            begin
                                head_next  = head_prev;
                                wr_en      = 1'b1;
                                wr_addr    = head_prev;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_PUSH_FULL;
                            end
                            else
                            begin
                                tail_next  = tail_succ;
                                wr_en      = 1'b1;
                                wr_addr    = tail_reg;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_none)
                            begin
                                status_next = ST_POP_EMPTY;
                            end
                            else
                            begin
                                head_next  = head_succ;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (is_none)
                            begin
                                status_next = ST_POP_EMPTY;
                            end
                            else
                            begin
                                tail_next  = tail_prev;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // Pointers now hold their updated values; the write has landed.
                rd_en      = 1'b1;
                state_next = S_CAPTURE;
            end
            S_CAPTURE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    front_next      = is_none ? '0 : front_rd;
                    back_next       = is_none ? '0 : back_rd;
                    empty_next      = is_none;
                    rsp_count_next  = count_reg;
                    rsp_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, pointers and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            status_reg     <= ST_OK;
            rsp_valid_reg  <= 1'b0;
            front_reg      <= '0;
            back_reg       <= '0;
            empty_reg      <= 1'b1;
            rsp_count_reg  <= '0;
            rsp_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            status_reg     <= status_next;
            rsp_valid_reg  <= rsp_valid_next;
            front_reg      <= front_next;
            back_reg       <= back_next;
            empty_reg      <= empty_next;
            rsp_count_reg  <= rsp_count_next;
            rsp_status_reg <= rsp_status_next;
        end
    end

endmodule

`default_nettype wire
